FILE: hdl/point_quantize_bit_packer_assert.svh
// ----------------------------------------------------------------------------
// point quantize bit packer assertion macros
// clocked on clk, held off while rst_n is low
// ----------------------------------------------------------------------------
`ifndef POINT_QUANTIZE_BIT_PACKER_ASSERT_SVH
`define POINT_QUANTIZE_BIT_PACKER_ASSERT_SVH

// antecedent in this cycle implies consequent in the same cycle
`define PQBP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent in this cycle implies consequent in the next cycle
`define PQBP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/pqbp_pkg.sv
// ----------------------------------------------------------------------------
// pqbp_pkg
// shared types and constants of the point quantizer and bit packer
// ----------------------------------------------------------------------------
package pqbp_pkg;

    localparam int COORD_W = 16;
    localparam int BYTE_W  = 8;
    localparam int ACT_W   = 2;
    localparam int BITS_W  = 5;
    localparam int AXES    = 3;

    localparam logic [BITS_W-1:0] BITS_RESET = 5'd8;

    localparam logic [ACT_W-1:0] ACT_START   = 2'd0;
    localparam logic [ACT_W-1:0] ACT_MEASURE = 2'd1;
    localparam logic [ACT_W-1:0] ACT_ENCODE  = 2'd2;
    localparam logic [ACT_W-1:0] ACT_FLUSH   = 2'd3;

    typedef struct packed {
        logic [ACT_W-1:0]   action;
        logic [COORD_W-1:0] coord_x;
        logic [COORD_W-1:0] coord_y;
        logic [COORD_W-1:0] coord_z;
    } pqbp_in_t;

    typedef struct packed {
        logic [BYTE_W-1:0] packed_byte;
        logic              run_last;
    } pqbp_out_t;

    // queued command, coordinates indexed by axis
    typedef struct packed {
        logic [ACT_W-1:0]                op;
        logic [AXES-1:0][COORD_W-1:0]    coord;
    } pqbp_cmd_t;

    typedef struct packed {
        logic start;
    } pqbp_div_req_t;

    typedef struct packed {
        logic done;
    } pqbp_div_rsp_t;

endpackage

FILE: hdl/pqbp_front.sv
// ----------------------------------------------------------------------------
// pqbp_front
// accepts input beats, sorts the coordinates by axis and queues up to two commands
// ----------------------------------------------------------------------------
module pqbp_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  pqbp_pkg::pqbp_in_t  in_data,
    output logic              cmd_valid,
    input  logic              cmd_ready,
    output pqbp_pkg::pqbp_cmd_t cmd
);
    import pqbp_pkg::*;

    pqbp_cmd_t  q_reg [0:1];
    logic       wp_reg, wp_next;
    logic       rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    pqbp_cmd_t  entry;
    logic       push, pop;

    always_comb
    begin
        entry.op       = in_data.action;
        entry.coord[0] = in_data.coord_x;
        entry.coord[1] = in_data.coord_y;
        entry.coord[2] = in_data.coord_z;
    end

    assign in_ready  = (cnt_reg != 2'd2);
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = q_reg[rp_reg];
    assign push      = in_valid && in_ready;
    assign pop       = cmd_valid && cmd_ready;

    always_comb
    begin
        wp_next  = push ? ~wp_reg : wp_reg;
        rp_next  = pop ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wp_reg] <= entry;
        end
    end

endmodule

FILE: hdl/pqbp_div.sv
// ----------------------------------------------------------------------------
// pqbp_div
// restoring radix-2 divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module pqbp_div #(
    parameter int QW = 32,
    parameter int DW = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  pqbp_pkg::pqbp_div_req_t req,
    input  logic [QW-1:0]          dividend,
    input  logic [DW-1:0]          divisor,
    output pqbp_pkg::pqbp_div_rsp_t rsp,
    output logic [QW-1:0]          quotient,
    output logic [DW-1:0]          remainder
);
    import pqbp_pkg::*;

    localparam int CW = $clog2(QW + 1);

    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [QW-1:0] acc_reg;
    logic [DW-1:0] rem_reg;
    logic [DW-1:0] dsr_reg;
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;

    assign trial = {rem_reg, acc_reg[QW-1]};
    assign ge    = (trial >= {1'b0, dsr_reg});
    assign diff  = trial - {1'b0, dsr_reg};

    assign rsp.done  = done_reg;
    assign quotient  = acc_reg;
    assign remainder = rem_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start && !busy_reg)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(QW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start && !busy_reg)
        begin
            acc_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            acc_reg <= {acc_reg[QW-2:0], ge};
            rem_reg <= ge ? diff[DW-1:0] : trial[DW-1:0];
        end
    end

endmodule

FILE: hdl/pqbp_back.sv
// ----------------------------------------------------------------------------
// pqbp_back
// executes queued commands: range tracking, quantizing and byte packing
// ----------------------------------------------------------------------------
module pqbp_back #(
    parameter int MAX_CODE_BITS = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [pqbp_pkg::BITS_W-1:0] cfg_wdata,
    input  logic                       cmd_valid,
    output logic                       cmd_ready,
    input  pqbp_pkg::pqbp_cmd_t        cmd,
    output logic                       out_valid,
    input  logic                       out_ready,
    output pqbp_pkg::pqbp_out_t        out_data,
    output pqbp_pkg::pqbp_div_req_t    div_req,
    output logic [pqbp_pkg::COORD_W+MAX_CODE_BITS-1:0] div_dividend,
    output logic [pqbp_pkg::COORD_W-1:0] div_divisor,
    input  pqbp_pkg::pqbp_div_rsp_t    div_rsp,
    input  logic [pqbp_pkg::COORD_W+MAX_CODE_BITS-1:0] div_quo,
    input  logic [pqbp_pkg::COORD_W-1:0] div_rem
);
    import pqbp_pkg::*;

    localparam int MB = MAX_CODE_BITS;
    localparam int QW = COORD_W + MB;
    localparam int BW = $clog2(MB + 1);
    localparam int NB = $clog2((7 + 3 * MB) / 8 + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MUL   = 3'd1;
    localparam logic [2:0] S_DGO   = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_PACK  = 3'd4;
    localparam logic [2:0] S_FLUSH = 3'd5;

    logic [2:0]         state_reg, state_next;
    logic [BITS_W-1:0]  bits_reg;
    logic [COORD_W-1:0] lo_reg [0:AXES-1];
    logic [COORD_W-1:0] hi_reg [0:AXES-1];
    logic [COORD_W-1:0] crd_reg [0:AXES-1];
    logic               seen_reg;
    logic [7:0]         pend_reg;
    logic [2:0]         cnt_reg;
    logic               emitted_reg;
    logic [NB-1:0]      left_reg;
    logic [BW-1:0]      eb_reg;
    logic [1:0]         axis_reg;
    logic [QW-1:0]      q_reg;
    logic [COORD_W-1:0] r_reg;
    logic [MB-1:0]      code_reg;
    logic [BW-1:0]      rbits_reg;
    logic               out_valid_reg;
    pqbp_out_t          out_data_reg;

    logic [BW-1:0]      eb;
    logic [MB-1:0]      top;
    logic [COORD_W-1:0] v, lo, hi;
    logic               zero_code;
    logic [QW:0]        rounded;
    logic [3:0]         space, k, newcnt;
    logic [MB+7:0]      code_ext;
    logic [7:0]         chunk, merged;
    logic               out_free;
    logic [7:0]         tot;

    always_comb
    begin
        if (bits_reg == '0)
        begin
            eb = BW'(1);
        end
        else if (32'(bits_reg) > MB)
        begin
            eb = BW'(MB);
        end
        else
        begin
            eb = BW'(bits_reg);
        end
    end

    assign top       = {MB{1'b1}} >> (BW'(MB) - eb_reg);
    assign v         = crd_reg[axis_reg];
    assign lo        = lo_reg[axis_reg];
    assign hi        = hi_reg[axis_reg];
    assign zero_code = (hi <= lo) || (v < lo);
    assign rounded   = {1'b0, div_quo} + (QW + 1)'({div_rem, 1'b0} >= {1'b0, r_reg});
    assign space     = 4'd8 - {1'b0, cnt_reg};
    assign k         = (32'(rbits_reg) >= 32'(space)) ? space : 4'(rbits_reg);
    assign newcnt    = {1'b0, cnt_reg} + k;
    assign code_ext  = {8'b0, code_reg};
    assign chunk     = code_ext[7:0] & (8'hFF >> (4'd8 - k));
    assign merged    = pend_reg | (chunk << cnt_reg);
    assign out_free  = !out_valid_reg || out_ready;
    assign tot       = 8'(cnt_reg) + 8'(3 * 32'(eb));

    assign cmd_ready    = (state_reg == S_IDLE);
    assign out_valid    = out_valid_reg;
    assign out_data     = out_data_reg;
    assign div_req.start = (state_reg == S_DGO);
    assign div_dividend = q_reg;
    assign div_divisor  = r_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    case (cmd.op)
                        ACT_ENCODE: state_next = S_MUL;
                        ACT_FLUSH:
                        begin
                            if (cnt_reg != 3'd0 || !emitted_reg)
                            begin
                                state_next = S_FLUSH;
                            end
                        end
                        default: state_next = S_IDLE;
                    endcase
                end
            end
            S_MUL:   state_next = zero_code ? S_PACK : S_DGO;
            S_DGO:   state_next = S_DIV;
            S_DIV:   state_next = div_rsp.done ? S_PACK : S_DIV;
            S_PACK:
            begin
                if ((newcnt != 4'd8 || out_free) && 32'(rbits_reg) == 32'(k))
                begin
                    state_next = (axis_reg == 2'd2) ? S_IDLE : S_MUL;
                end
            end
            S_FLUSH: state_next = out_free ? S_IDLE : S_FLUSH;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            bits_reg      <= BITS_RESET;
            seen_reg      <= 1'b0;
            pend_reg      <= '0;
            cnt_reg       <= '0;
            emitted_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            axis_reg      <= '0;
            for (int i = 0; i < AXES; i++)
            begin
                lo_reg[i] <= '0;
                hi_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                bits_reg <= cfg_wdata;
            end
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        case (cmd.op)
                            ACT_START:
                            begin
                                seen_reg    <= 1'b0;
                                pend_reg    <= '0;
                                cnt_reg     <= '0;
                                emitted_reg <= 1'b0;
                                for (int i = 0; i < AXES; i++)
                                begin
                                    lo_reg[i] <= '0;
                                    hi_reg[i] <= '0;
                                end
                            end
                            ACT_MEASURE:
                            begin
                                seen_reg <= 1'b1;
                                for (int i = 0; i < AXES; i++)
                                begin
                                    if (!seen_reg || cmd.coord[i] < lo_reg[i])
                                    begin
                                        lo_reg[i] <= cmd.coord[i];
                                    end
                                    if (!seen_reg || cmd.coord[i] > hi_reg[i])
                                    begin
                                        hi_reg[i] <= cmd.coord[i];
                                    end
                                end
                            end
                            ACT_ENCODE:
                            begin
                                axis_reg <= 2'd0;
                            end
                            default:
                            begin
                                // flush with nothing to send only clears the empty partial byte and sends nothing
                                if (cnt_reg == 3'd0 && emitted_reg)
                                begin
                                    pend_reg <= '0;
                                    cnt_reg  <= '0;
                                end
                            end
                        endcase
                    end
                end
                S_PACK:
                begin
                    if (newcnt == 4'd8)
                    begin
                        if (out_free)
                        begin
                            out_valid_reg <= 1'b1;
                            pend_reg      <= '0;
                            cnt_reg       <= '0;
                            emitted_reg   <= 1'b1;
                        end
                    end
                    else
                    begin
                        pend_reg <= merged;
                        cnt_reg  <= newcnt[2:0];
                    end
                    if ((newcnt != 4'd8 || out_free) && 32'(rbits_reg) == 32'(k))
                    begin
                        axis_reg <= axis_reg + 2'd1;
                    end
                end
                S_FLUSH:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        pend_reg      <= '0;
                        cnt_reg       <= '0;
                        emitted_reg   <= 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // datapath registers, no reset needed
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    for (int i = 0; i < AXES; i++)
                    begin
                        crd_reg[i] <= cmd.coord[i];
                    end
                    eb_reg   <= eb;
                    left_reg <= NB'(tot >> 3);
                end
            end
            S_MUL:
            begin
                q_reg     <= QW'(v - lo) * QW'(top);
                r_reg     <= hi - lo;
                code_reg  <= '0;
                rbits_reg <= eb_reg;
            end
            S_DIV:
            begin
                if (div_rsp.done)
                begin
                    code_reg <= (rounded > (QW + 1)'(top)) ? top : rounded[MB-1:0];
                end
            end
            S_PACK:
            begin
                if (newcnt != 4'd8 || out_free)
                begin
                    code_reg  <= code_reg >> k;
                    rbits_reg <= rbits_reg - BW'(k);
                end
                if (newcnt == 4'd8 && out_free)
                begin
                    out_data_reg.packed_byte <= merged;
                    out_data_reg.run_last    <= (left_reg == NB'(1));
                    left_reg                 <= left_reg - NB'(1);
                end
            end
            S_FLUSH:
            begin
                if (out_free)
                begin
                    out_data_reg.packed_byte <= pend_reg;
                    out_data_reg.run_last    <= 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

FILE: hdl/point_quantize_bit_packer.sv
// ----------------------------------------------------------------------------
// point_quantize_bit_packer
// 3-d point range tracker, uniform quantizer and lsb-first byte packer
// ----------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  in        input      in_valid/in_ready    pqbp_in_t   (action, coord_x/y/z)
//  out       output     out_valid/out_ready  pqbp_out_t  (packed_byte, run_last)
//  cfg       input      cfg_we               cfg_wdata   (bits_per_value)
//
//  start, measure and an idle flush end in the back end's idle state; a flush
//  that sends a byte waits in the flush state. encode takes each axis through
//  multiply, divide (one quotient bit per cycle) and pack; a zero code skips
//  the divide. a two-beat queue lets the front take beats while the back end
//  works. rst_n clears control state at once; out stalls freeze the back end.
// ----------------------------------------------------------------------------
module point_quantize_bit_packer #(
    parameter int MAX_CODE_BITS = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  pqbp_pkg::pqbp_in_t          in_data,
    output logic                        out_valid,
    input  logic                        out_ready,
    output pqbp_pkg::pqbp_out_t         out_data,
    input  logic                        cfg_we,
    input  logic [pqbp_pkg::BITS_W-1:0] cfg_wdata
);
    import pqbp_pkg::*;

    localparam int QW = COORD_W + MAX_CODE_BITS;

    logic          cmd_valid, cmd_ready;
    pqbp_cmd_t     cmd;
    pqbp_div_req_t div_req;
    pqbp_div_rsp_t div_rsp;
    logic [QW-1:0]      div_dividend, div_quo;
    logic [COORD_W-1:0] div_divisor, div_rem;

    pqbp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    pqbp_div #(
        .QW (QW),
        .DW (COORD_W)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (div_req),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .rsp       (div_rsp),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    pqbp_back #(
        .MAX_CODE_BITS (MAX_CODE_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .cmd_valid    (cmd_valid),
        .cmd_ready    (cmd_ready),
        .cmd          (cmd),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_data     (out_data),
        .div_req      (div_req),
        .div_dividend (div_dividend),
        .div_divisor  (div_divisor),
        .div_rsp      (div_rsp),
        .div_quo      (div_quo),
        .div_rem      (div_rem)
    );

`include "point_quantize_bit_packer_assert.svh"

    `PQBP_ASSERT_NOW(a_full_has_cmd, !in_ready, cmd_valid, "queue full but no command")
    `PQBP_ASSERT_NEXT(a_cmd_hold, cmd_valid && !cmd_ready, cmd_valid && $stable(cmd), "queued command changed while waiting")
    `PQBP_ASSERT_NOW(a_div_idle_start, div_req.start, !div_rsp.done, "divider started while finishing")

endmodule
